/* rtl/ial_pkg.sv */
`default_nettype none

package ial_pkg;

    // default sizes of the list
    localparam int unsigned CAPACITY_DEF      = 64;
    localparam int unsigned ELEMENT_WIDTH_DEF = 64;

    // fixed port widths
    localparam int unsigned OP_W      = 3;
    localparam int unsigned POS_W     = 7;
    localparam int unsigned PAYLOAD_W = 64;
    localparam int unsigned COUNT_W   = 7;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_ERASE  = 3'd1,
        OP_PUSH   = 3'd2,
        OP_POP    = 3'd3,
        OP_GET    = 3'd4,
        OP_SET    = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT_UP,
        ST_INS_WR,
        ST_SHIFT_DN,
        ST_GET_WAIT
    } t_state;

endpackage

`default_nettype wire

/* rtl/ial_ram.sv */
`default_nettype none

module ial_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64,
    localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/indexed_array_list.sv */
// indexed_array_list: bounded ordered list of payload words kept in one
// synchronous ram of CAPACITY entries.
//
// command channel: an item (op, position, element) is taken at a rising
// edge where start is high and busy is low. ops: insert, erase, push,
// pop, get, set. result channel: o_valid is high for exactly one cycle
// with o_ok, o_read_element and o_count; the receiver cannot stall it.
//
// order: push, pop, set, a failed op, insert at the tail and erase of the
// tail give their result in the cycle after acceptance; get waits in
// ST_GET_WAIT for the ram read. insert moves count-position entries up
// through ST_SHIFT_UP, then writes the new entry in ST_INS_WR; erase moves
// count-position-1 entries down through ST_SHIFT_DN. every moved entry
// takes one ram read and one ram write through the single read and single
// write port. busy drops with the result strobe, so the next item may be
// taken in the cycle the result is shown.
//
// reset clears the entry count and the control state only; the ram holds
// no reset value and needs no clearing pass.
`default_nettype none

module indexed_array_list
    import ial_pkg::*;
#(
    parameter int unsigned CAPACITY      = CAPACITY_DEF,
    parameter int unsigned ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [OP_W-1:0]      i_op,
    input  wire logic [POS_W-1:0]     i_position,
    input  wire logic [PAYLOAD_W-1:0] i_element,
    output logic                      o_valid,
    output logic                      o_ok,
    output logic [PAYLOAD_W-1:0]      o_read_element,
    output logic [COUNT_W-1:0]        o_count
);

    localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    // common width for comparing position against the count
    localparam int unsigned CMPW = (CW > POS_W) ? CW : POS_W;
    localparam int unsigned EW   = ELEMENT_WIDTH;

    // control and payload registers
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [AW-1:0]   r_idx,   n_idx;    // address of the read in flight
    logic [AW-1:0]   r_pos,   n_pos;
    logic [EW-1:0]   r_elem,  n_elem;
    logic            r_valid, n_valid;
    logic            r_ok,    n_ok;
    logic [EW-1:0]   r_rd,    n_rd;

    // ram port
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [EW-1:0]   mem_wdata;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    logic [EW-1:0]   mem_rdata;

    ial_ram #(
        .WIDTH (EW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // position and count checks on the incoming item
    logic [CMPW-1:0] w_pos_x;
    logic [CMPW-1:0] w_cnt_x;
    logic [CW-1:0]   w_cnt_m1;
    logic [AW-1:0]   w_pos_addr;
    logic [AW-1:0]   w_cnt_m1_addr;
    logic            w_full;
    logic            w_pos_lt;   // position names a live entry
    logic            w_pos_le;   // position is a legal insert slot
    logic            w_pos_tail; // position is the last live entry

    assign w_pos_x       = CMPW'(i_position);
    assign w_cnt_x       = CMPW'(r_count);
    assign w_cnt_m1      = r_count - CW'(1);
    assign w_pos_addr    = w_pos_x[AW-1:0];
    assign w_cnt_m1_addr = w_cnt_m1[AW-1:0];
    assign w_full        = (r_count == CW'(CAPACITY));
    assign w_pos_lt      = (w_pos_x <  w_cnt_x);
    assign w_pos_le      = (w_pos_x <= w_cnt_x);
    assign w_pos_tail    = (w_pos_x == CMPW'(w_cnt_m1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_pos  <= n_pos;
        r_elem <= n_elem;
        r_ok   <= n_ok;
        r_rd   <= n_rd;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_elem    = r_elem;
        n_valid   = 1'b0;
        n_ok      = 1'b0;
        n_rd      = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = r_elem;
        mem_re    = 1'b0;
        mem_raddr = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_pos   = w_pos_addr;
                    n_elem  = i_element[EW-1:0];
                    // failed ops report at once; overridden below on success
                    n_valid = 1'b1;
                    unique case (t_op'(i_op))
                        OP_INSERT: begin
                            if (w_pos_le && !w_full) begin
                                if (w_pos_x == w_cnt_x) begin
                                    // insert at the tail: nothing to move
                                    mem_we    = 1'b1;
                                    mem_waddr = w_pos_addr;
                                    mem_wdata = i_element[EW-1:0];
                                    n_count   = r_count + CW'(1);
                                    n_ok      = 1'b1;
                                end else begin
                                    // start moving from the last entry down
                                    mem_re    = 1'b1;
                                    mem_raddr = w_cnt_m1_addr;
                                    n_idx     = w_cnt_m1_addr;
                                    n_valid   = 1'b0;
                                    n_state   = ST_SHIFT_UP;
                                end
                            end
                        end
                        OP_ERASE: begin
                            if (w_pos_lt) begin
                                if (w_pos_tail) begin
                                    // erase of the last entry drops it
                                    n_count = w_cnt_m1;
                                    n_ok    = 1'b1;
                                end else begin
                                    mem_re    = 1'b1;
                                    mem_raddr = w_pos_addr + AW'(1);
                                    n_idx     = w_pos_addr + AW'(1);
                                    n_valid   = 1'b0;
                                    n_state   = ST_SHIFT_DN;
                                end
                            end
                        end
                        OP_PUSH: begin
                            if (!w_full) begin
                                mem_we    = 1'b1;
                                mem_waddr = w_cnt_x[AW-1:0];
                                mem_wdata = i_element[EW-1:0];
                                n_count   = r_count + CW'(1);
                                n_ok      = 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_count != '0) begin
                                n_count = w_cnt_m1;
                                n_ok    = 1'b1;
                            end
                        end
                        OP_GET: begin
                            if (w_pos_lt) begin
                                mem_re    = 1'b1;
                                mem_raddr = w_pos_addr;
                                n_valid   = 1'b0;
                                n_state   = ST_GET_WAIT;
                            end
                        end
                        OP_SET: begin
                            if (w_pos_lt) begin
                                mem_we    = 1'b1;
                                mem_waddr = w_pos_addr;
                                mem_wdata = i_element[EW-1:0];
                                n_ok      = 1'b1;
                            end
                        end
                        default: begin
                            // unused op codes fail and change nothing
                        end
                    endcase
                end
            end
            ST_SHIFT_UP: begin
                // entry read last cycle moves one slot up
                mem_we    = 1'b1;
                mem_waddr = r_idx + AW'(1);
                mem_wdata = mem_rdata;
                if (r_idx == r_pos) begin
                    n_state = ST_INS_WR;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx - AW'(1);
                    n_idx     = r_idx - AW'(1);
                end
            end
            ST_INS_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos;
                mem_wdata = r_elem;
                n_count   = r_count + CW'(1);
                n_valid   = 1'b1;
                n_ok      = 1'b1;
                n_state   = ST_IDLE;
            end
            ST_SHIFT_DN: begin
                // entry read last cycle moves one slot down
                mem_we    = 1'b1;
                mem_waddr = r_idx - AW'(1);
                mem_wdata = mem_rdata;
                if (r_idx == w_cnt_m1_addr) begin
                    n_count = w_cnt_m1;
                    n_valid = 1'b1;
                    n_ok    = 1'b1;
                    n_state = ST_IDLE;
                end else begin
                    mem_re    = 1'b1;
                    mem_raddr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end
            ST_GET_WAIT: begin
                n_valid = 1'b1;
                n_ok    = 1'b1;
                n_rd    = mem_rdata;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // outputs
    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_valid;
    assign o_ok           = r_ok;
    assign o_read_element = PAYLOAD_W'(r_rd);
    // count is updated on the same edge that raises the strobe
    assign o_count        = w_cnt_x[COUNT_W-1:0];

    // the list never holds more than its capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // a move never reads the slot it writes in the same cycle
    a_no_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("ram read and write hit the same entry");

    // the count only changes together with a result
    a_count_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> o_valid)
        else $error("count changed without a result");

    // a push into a full list fails on the next cycle
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_PUSH) && w_full) |=> (o_valid && !o_ok))
        else $error("push into full list did not fail");

endmodule

`default_nettype wire
